// ----- rtl/fba_pkg.sv -----
// Shared types and constants of the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int FRAME_W   = 12;
  localparam int FC_W      = 13;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int STATUS_W  = 3;
  localparam int ADDR_W    = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_FRAME_COUNT = 1'b0;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_HAD_FRAME = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FREED     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOTHING   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_MODIFY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                load;
    logic                latch_addr;
    logic                rd;
    logic                write;
    logic                emit;
    logic [STATUS_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic pf_zero;
    logic pf_in_range;
    logic word_found;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- rtl/fba_ctrl.sv -----
// Controller state machine: sequences decide, read and modify steps per item.
`timescale 1ns / 1ps

module fba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fba_pkg::dp_stat_t stat,
  output fba_pkg::dp_cmd_t  cmd
);
  import fba_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= STAT_NOTHING;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next     = state;
    code_next      = code;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.latch_addr = 1'b0;
    cmd.rd         = 1'b0;
    cmd.write      = 1'b0;
    cmd.emit       = 1'b0;
    cmd.code       = code;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.latch_addr = 1'b1;
        if (!stat.op_free) begin
          if (!stat.pf_zero) begin
            code_next  = STAT_HAD_FRAME;
            state_next = S_EMIT;
          end else if (stat.word_found) begin
            state_next = S_READ;
          end else begin
            code_next  = STAT_NO_FREE;
            state_next = S_EMIT;
          end
        end else begin
          if (stat.pf_zero) begin
            code_next  = STAT_NOTHING;
            state_next = S_EMIT;
          end else if (stat.pf_in_range) begin
            state_next = S_READ;
          end else begin
            // frame beyond the bitmap: nothing to clear
            code_next  = STAT_FREED;
            state_next = S_EMIT;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        cmd.code = stat.op_free ? STAT_FREED : STAT_ALLOCATED;
        // hold the write back until the output register can take the item
        if (!stat.out_busy) begin
          cmd.write  = 1'b1;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fba_datapath.sv -----
// Datapath: bitmap memory, per-word full flags, word and bit search, result register.
`timescale 1ns / 1ps

module fba_datapath #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fba_pkg::dp_cmd_t              cmd,
  output fba_pkg::dp_stat_t             stat,
  input  logic [fba_pkg::FC_W-1:0]      frame_count,
  input  logic                          operation,
  input  logic [fba_pkg::FRAME_W-1:0]   page_frame,
  input  logic                          kernel_page,
  input  logic                          write_access,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fba_pkg::FRAME_W-1:0]   frame,
  output logic                          present,
  output logic                          writeable,
  output logic                          user_mode,
  output logic [fba_pkg::STATUS_W-1:0]  status
);
  import fba_pkg::*;

  localparam int          WORDS     = NUM_FRAMES / WORD_BITS;
  // Only the words below 256 can ever be searched or freed.
  localparam int          MEM_WORDS = (WORDS < 256) ? WORDS : 256;
  localparam int          IDX_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [31:0] NF        = 32'(NUM_FRAMES);

  logic                 op_q;
  logic [FRAME_W-1:0]   pf_q;
  logic                 kern_q;
  logic                 wr_q;
  logic [IDX_W-1:0]     addr_q;

  logic [WORD_BITS-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid;
  logic [MEM_WORDS-1:0] full;
  logic [WORD_BITS-1:0] rdata;
  logic                 rvalid;

  logic [FC_W-1:0]      limit;
  logic [7:0]           wlim;
  logic [MEM_WORDS-1:0] cand;
  logic [IDX_W-1:0]     sel_word;
  logic                 found;
  logic [WORD_BITS-1:0] word;
  logic [BIT_W-1:0]     bit_sel;
  logic [WORD_BITS-1:0] new_word;
  logic [FRAME_W-1:0]   pick_frame;
  logic                 is_alloc;

  // Word search over the full flags, clamped to whole words below frame_count
  always_comb begin
    limit    = (32'(frame_count) > NF) ? FC_W'(NF) : frame_count;
    wlim     = limit[FC_W-1:BIT_W];
    sel_word = '0;
    found    = 1'b0;
    for (int w = 0; w < MEM_WORDS; w++) begin
      cand[w] = !full[w] && (9'(w) < {1'b0, wlim});
    end
    for (int w = MEM_WORDS - 1; w >= 0; w--) begin
      if (cand[w]) begin
        sel_word = IDX_W'(w);
        found    = 1'b1;
      end
    end
  end

  // Lowest clear bit of the word read back, and the word with that bit set (allocate) or the freed bit cleared
  always_comb begin
    word    = rvalid ? rdata : '0;
    bit_sel = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) bit_sel = BIT_W'(b);
    end
    if (op_q) begin
      new_word = word & ~(WORD_BITS'(1) << pf_q[BIT_W-1:0]);
    end else begin
      new_word = word | (WORD_BITS'(1) << bit_sel);
    end
    pick_frame = FRAME_W'({addr_q, bit_sel});
  end

  assign stat.op_free     = op_q;
  assign stat.pf_zero     = (pf_q == '0);
  assign stat.pf_in_range = (32'(pf_q) < NF);
  assign stat.word_found  = found;
  assign stat.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      pf_q   <= page_frame;
      kern_q <= kernel_page;
      wr_q   <= write_access;
    end
    if (cmd.latch_addr) begin
      addr_q <= op_q ? IDX_W'(pf_q[FRAME_W-1:BIT_W]) : sel_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) mem[addr_q] <= new_word;
    if (cmd.rd) begin
      rdata  <= mem[addr_q];
      rvalid <= valid[addr_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      full  <= '0;
    end else if (cmd.write) begin
      valid[addr_q] <= 1'b1;
      full[addr_q]  <= &new_word;
    end
  end

  assign is_alloc = (cmd.code == STAT_ALLOCATED);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (is_alloc) begin
        frame <= pick_frame;
      end else if (cmd.code == STAT_HAD_FRAME) begin
        frame <= pf_q;
      end else begin
        frame <= '0;
      end
      present   <= is_alloc;
      writeable <= is_alloc && wr_q;
      user_mode <= is_alloc && !kern_q;
      status    <= cmd.code;
    end
  end

endmodule

// ----- rtl/frame_bitmap_allocator_core.sv -----
// Top level of the frame bitmap allocator: config register, controller and datapath.
`timescale 1ns / 1ps
//
// First-fit page frame allocator over a used/free bitmap, 32 frames per word.
// Input channel (in_valid/in_ready) takes one request item: operation, page_frame,
// kernel_page, write_access. Output channel (out_valid/out_ready) returns exactly one
// result item per request: frame, present, writeable, user_mode, status.
// One item is worked at a time. An allocate or free that touches the bitmap passes
// through acceptance, word pick from the per-word full flags, bitmap read, then bit
// scan and write back before the next acceptance; a request that changes nothing
// goes from the word pick to its result. The single-port bitmap read-modify-write
// sets this order. The result is registered with the write back, or after the word
// pick when the bitmap is untouched. The result sits in an output register; the next
// item is accepted while it waits. If the receiver stalls, the block holds the
// following result, and its write back, until the output register frees up.
// frame_count is written over the APB-style port at byte address 0 and reads back.
// Reset (rst, synchronous) marks every frame free at once through per-word valid and
// full flags, returns the controller to idle and loads frame_count with NUM_FRAMES.
//
module frame_bitmap_allocator_core #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fba_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [fba_pkg::FRAME_W-1:0]   page_frame,
  input  logic                          kernel_page,
  input  logic                          write_access,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fba_pkg::FRAME_W-1:0]   frame,
  output logic                          present,
  output logic                          writeable,
  output logic                          user_mode,
  output logic [fba_pkg::STATUS_W-1:0]  status
);
  import fba_pkg::*;

  logic [FC_W-1:0] frame_count;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_COUNT) ? 32'(frame_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FC_W'(NUM_FRAMES);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_COUNT)) begin
      frame_count <= pwdata[FC_W-1:0];
    end
  end

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fba_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .frame_count  (frame_count),
    .operation    (operation),
    .page_frame   (page_frame),
    .kernel_page  (kernel_page),
    .write_access (write_access),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame        (frame),
    .present      (present),
    .writeable    (writeable),
    .user_mode    (user_mode),
    .status       (status)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_alloc_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_ALLOCATED)) |-> present)
    else $error("allocated result without present bit");

  a_other_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_ALLOCATED)) |-> (!present && !writeable && !user_mode))
    else $error("page entry bits set on a non-allocating result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !in_ready) |=> out_valid)
    else $error("stalled result dropped while an item is in work");
`endif

endmodule
